### hw/rtl/stt_pkg.sv
// Shared types, token codes and keyword table for the SQL text tokenizer.
package stt_pkg;

	localparam int POS_BITS_DEF = 16;
	localparam int KW_MAX_LEN_DEF = 14;
	localparam int KW_COUNT = 27;
	localparam int KW_TEXT_BYTES = 16;
	localparam int Q_DEPTH = 8;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [5:0] T_IDENT   = 6'd0;
	localparam logic [5:0] T_NUMBER  = 6'd1;
	localparam logic [5:0] T_STRING  = 6'd2;
	localparam logic [5:0] T_KW_BASE = 6'd3;
	localparam logic [5:0] T_PLUS    = 6'd30;
	localparam logic [5:0] T_MINUS   = 6'd31;
	localparam logic [5:0] T_STAR    = 6'd32;
	localparam logic [5:0] T_SLASH   = 6'd33;
	localparam logic [5:0] T_EQ      = 6'd34;
	localparam logic [5:0] T_LT      = 6'd35;
	localparam logic [5:0] T_GT      = 6'd36;
	localparam logic [5:0] T_LTEQ    = 6'd37;
	localparam logic [5:0] T_GTEQ    = 6'd38;
	localparam logic [5:0] T_COMMA   = 6'd39;
	localparam logic [5:0] T_SEMI    = 6'd40;
	localparam logic [5:0] T_LPAREN  = 6'd41;
	localparam logic [5:0] T_RPAREN  = 6'd42;
	localparam logic [5:0] T_END     = 6'd43;

	localparam logic [1:0] E_NONE    = 2'd0;
	localparam logic [1:0] E_UNKNOWN = 2'd1;
	localparam logic [1:0] E_UNTERM  = 2'd2;

	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_US     = 8'h5F;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;

	typedef enum logic [3:0] {
		M_IDLE, M_WORD, M_STR, M_ESC, M_INT, M_FRAC, M_LT, M_GT, M_ERR
	} lex_mode_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       has_char;
		logic       last;
	} in_t;

	typedef struct packed {
		logic [5:0]  token_type;
		logic [15:0] start_pos;
		logic [15:0] token_len;
		logic [1:0]  error_code;
		logic        overflow;
		logic        last_of_run;
	} out_t;

	typedef struct packed {
		logic [1:0]     n;
		out_t [2:0]     slot;
	} push_t;

	typedef logic [8*KW_TEXT_BYTES-1:0] kw_text_t;

	// text is right-justified: char i of a word of length L sits at byte L-1-i
	localparam kw_text_t KW_TEXT [KW_COUNT] = '{
		"SELECT", "FROM", "WHERE", "AND", "OR", "ORDER", "GROUP", "BY", "CREATE",
		"DATABASE", "TABLE", "IN", "PRIMARY", "KEY", "UNIQUE", "NOT", "NULL",
		{"AUTO_", "INCREMENT"}, "INSERT", "INTO", "VALUES", "UPDATE", "SET", "DELETE",
		"USE", "DESCRIBE", "CATALOG"
	};

	localparam logic [4:0] KW_LEN [KW_COUNT] = '{
		5'd6, 5'd4, 5'd5, 5'd3, 5'd2, 5'd5, 5'd5, 5'd2, 5'd6,
		5'd8, 5'd5, 5'd2, 5'd7, 5'd3, 5'd6, 5'd3, 5'd4,
		5'd14, 5'd6, 5'd4, 5'd6, 5'd6, 5'd3, 5'd6,
		5'd3, 5'd8, 5'd7
	};

	function automatic logic [5:0] kw_lookup(input logic [KW_TEXT_BYTES-1:0][7:0] wb,
		input logic [4:0] len);
		logic [5:0] t;
		logic       hit;
		int         b;
		t = T_IDENT;
		for (int k = KW_COUNT - 1; k >= 0; k--) begin
			hit = (KW_LEN[k] == len);
			for (int i = 0; i < KW_TEXT_BYTES; i++) begin
				if (i < int'(KW_LEN[k])) begin
					b = int'(KW_LEN[k]) - 1 - i;
					hit = hit && (wb[i] == KW_TEXT[k][8*b +: 8]);
				end
			end
			if (hit) t = 6'(int'(T_KW_BASE) + k);
		end
		return t;
	endfunction

endpackage

### hw/rtl/sql_text_tokenizer.sv
// Top level of the SQL text tokenizer: lexer front, record queue, output.
//
// channel  dir  payload  handshake
// text     in   in_t     text_valid / text_stall
// token    out  out_t    token_valid / token_stall
//
// One byte is taken per cycle while text_stall is low; each byte yields zero to three records.
// Records drain at one per cycle while token_stall is low, from an 8-entry queue through the output register.
// text_stall rises while fewer than three queue entries are free.
// A byte's records enter the queue as the byte is taken; token_valid rises when one loads the output register.
// Reset (arst_n low) clears lexer state, queue and output valid.
module sql_text_tokenizer import stt_pkg::*; #(
	parameter int POS_BITS = POS_BITS_DEF,
	parameter int KEYWORD_MAX_LEN = KW_MAX_LEN_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic text_valid,
	output logic text_stall,
	input  in_t  text,
	output logic token_valid,
	input  logic token_stall,
	output out_t token
);

	push_t push;
	logic  full;

	assign text_stall = full;

	stt_front #(
		.POS_BITS(POS_BITS),
		.KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(text_valid && !full),
		.text(text),
		.push(push)
	);

	stt_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.token_valid(token_valid),
		.token_stall(token_stall),
		.token(token)
	);

endmodule

### hw/rtl/stt_front.sv
// Lexer front end: per-byte classification and token record generation.
module stt_front import stt_pkg::*; #(
	parameter int POS_BITS = POS_BITS_DEF,
	parameter int KEYWORD_MAX_LEN = KW_MAX_LEN_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  accept,
	input  in_t   text,
	output push_t push
);

	localparam int IDX_W = $clog2(KEYWORD_MAX_LEN);
	localparam logic [POS_BITS-1:0] POS_MAX = '1;
	localparam logic [POS_BITS-1:0] KW_MAX_P = POS_BITS'(KEYWORD_MAX_LEN);

	lex_mode_t           mode_q, mode_b, mode_n;
	logic [POS_BITS-1:0] tstart_q, tstart_b, tstart_n;
	logic [POS_BITS-1:0] tlen_q, tlen_b, tlen_n;
	logic [POS_BITS-1:0] pos_q, pos_b, pos_n;
	logic                sat_q, sat_b, sat_n;
	logic [7:0]          wbuf_q [KEYWORD_MAX_LEN];
	logic [7:0]          wbuf_b [KEYWORD_MAX_LEN];

	logic [7:0] c;
	logic byte_take, c_alpha, c_digit, c_space, c_op, c_wstart, c_wchar, c_unknown;
	logic restart, end_take;
	logic [KW_TEXT_BYTES-1:0][7:0] wq16, wb16;
	logic [5:0] kw_q, kw_b;

	function automatic logic [POS_BITS:0] inc(input logic [POS_BITS-1:0] v);
		if (v == POS_MAX) return {1'b1, v};
		return {1'b0, v + 1'b1};
	endfunction

	function automatic logic [15:0] to16(input logic [POS_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[15:0];
	endfunction

	function automatic out_t mk(input logic [5:0] t, input logic [POS_BITS-1:0] s,
		input logic [POS_BITS-1:0] l, input logic [1:0] e, input logic f);
		out_t r;
		r.token_type  = t;
		r.start_pos   = to16(s);
		r.token_len   = to16(l);
		r.error_code  = e;
		r.overflow    = f;
		r.last_of_run = 1'b0;
		return r;
	endfunction

	function automatic logic [5:0] op_code(input logic [7:0] x);
		logic [5:0] t;
		case (x)
			"+":     t = T_PLUS;
			"-":     t = T_MINUS;
			"*":     t = T_STAR;
			"/":     t = T_SLASH;
			"=":     t = T_EQ;
			",":     t = T_COMMA;
			";":     t = T_SEMI;
			"(":     t = T_LPAREN;
			")":     t = T_RPAREN;
			default: t = T_IDENT;
		endcase
		return t;
	endfunction

	assign c         = text.ch;
	assign byte_take = accept && text.has_char;
	assign end_take  = accept && text.last;
	assign c_alpha   = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	assign c_digit   = (c >= "0" && c <= "9");
	assign c_space   = (c == " ") || (c >= 8'd9 && c <= 8'd13);
	assign c_op      = (op_code(c) != T_IDENT);
	assign c_wstart  = c_alpha || (c == CH_US);
	assign c_wchar   = c_wstart || c_digit;
	assign c_unknown = !c_space && !c_op && !c_wstart && !c_digit && (c != CH_LT)
		&& (c != CH_GT) && (c != CH_QUOTE);

	// byte ends the pending token (or none was pending) and is lexed from idle
	assign restart = byte_take && ((mode_q == M_IDLE)
		|| (mode_q == M_WORD && !c_wchar)
		|| (mode_q == M_INT && !c_digit && c != CH_DOT)
		|| (mode_q == M_FRAC && !c_digit)
		|| ((mode_q == M_LT || mode_q == M_GT) && c != CH_EQ));

	always_comb begin
		wq16 = '0;
		wb16 = '0;
		for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
			wq16[i] = wbuf_q[i];
			wb16[i] = wbuf_b[i];
		end
		kw_q = (tlen_q <= KW_MAX_P) ? kw_lookup(wq16, 5'(tlen_q)) : T_IDENT;
		kw_b = (tlen_b <= KW_MAX_P) ? kw_lookup(wb16, 5'(tlen_b)) : T_IDENT;
	end

	// next state
	always_comb begin
		logic [POS_BITS:0] r;
		logic              sf;
		mode_b   = mode_q;
		tstart_b = tstart_q;
		tlen_b   = tlen_q;
		pos_b    = pos_q;
		wbuf_b   = wbuf_q;
		sf       = 1'b0;
		r        = '0;
		if (byte_take) begin
			r = inc(pos_q);
			pos_b = r[POS_BITS-1:0];
			sf = r[POS_BITS];
			unique case (mode_q)
				M_WORD: begin
					if (c_wchar) begin
						if (tlen_q < KW_MAX_P) wbuf_b[tlen_q[IDX_W-1:0]] = c;
						r = inc(tlen_q);
						tlen_b = r[POS_BITS-1:0];
						sf = sf | r[POS_BITS];
					end
				end
				M_STR: begin
					if (c == CH_QUOTE) begin
						mode_b = M_IDLE;
					end else begin
						if (c == CH_BSLASH) mode_b = M_ESC;
						r = inc(tlen_q);
						tlen_b = r[POS_BITS-1:0];
						sf = sf | r[POS_BITS];
					end
				end
				M_ESC: begin
					r = inc(tlen_q);
					tlen_b = r[POS_BITS-1:0];
					sf = sf | r[POS_BITS];
					mode_b = M_STR;
				end
				M_INT, M_FRAC: begin
					if (c_digit || (c == CH_DOT && mode_q == M_INT)) begin
						r = inc(tlen_q);
						tlen_b = r[POS_BITS-1:0];
						sf = sf | r[POS_BITS];
						if (!c_digit) mode_b = M_FRAC;
					end
				end
				M_LT, M_GT: begin
					if (c == CH_EQ) mode_b = M_IDLE;
				end
				default: ;
			endcase
			if (restart) begin
				mode_b = M_IDLE;
				if (!c_op && !c_space) begin
					tstart_b = pos_q;
					tlen_b = POS_BITS'(1);
					if (c_wstart) begin
						wbuf_b[0] = c;
						mode_b = M_WORD;
					end else if (c_digit) begin
						mode_b = M_INT;
					end else if (c == CH_LT) begin
						mode_b = M_LT;
					end else if (c == CH_GT) begin
						mode_b = M_GT;
					end else if (c == CH_QUOTE) begin
						r = inc(pos_q);
						tstart_b = r[POS_BITS-1:0];
						sf = sf | r[POS_BITS];
						tlen_b = '0;
						mode_b = M_STR;
					end else begin
						mode_b = M_ERR;
					end
				end
			end
		end
		sat_b = sat_q | sf;
		if (end_take) begin
			mode_n   = M_IDLE;
			tstart_n = '0;
			tlen_n   = '0;
			pos_n    = '0;
			sat_n    = 1'b0;
		end else begin
			mode_n   = mode_b;
			tstart_n = tstart_b;
			tlen_n   = tlen_b;
			pos_n    = pos_b;
			sat_n    = sat_b;
		end
	end

	// records: close of pending token, one-byte token, flush at end, End
	always_comb begin
		logic [3:0] cv;
		out_t       cr [4];
		cv = '0;
		for (int j = 0; j < 4; j++) cr[j] = '0;
		if (byte_take) begin
			unique case (mode_q)
				M_WORD: begin
					cv[0] = !c_wchar;
					cr[0] = mk(kw_q, tstart_q, tlen_q, E_NONE, sat_q);
				end
				M_STR: begin
					cv[0] = (c == CH_QUOTE);
					cr[0] = mk(T_STRING, tstart_q, tlen_q, E_NONE, sat_q);
				end
				M_INT, M_FRAC: begin
					cv[0] = restart;
					cr[0] = mk(T_NUMBER, tstart_q, tlen_q, E_NONE, sat_q);
				end
				M_LT: begin
					cv[0] = 1'b1;
					cr[0] = (c == CH_EQ) ? mk(T_LTEQ, tstart_q, POS_BITS'(2), E_NONE, sat_q)
						: mk(T_LT, tstart_q, POS_BITS'(1), E_NONE, sat_q);
				end
				M_GT: begin
					cv[0] = 1'b1;
					cr[0] = (c == CH_EQ) ? mk(T_GTEQ, tstart_q, POS_BITS'(2), E_NONE, sat_q)
						: mk(T_GT, tstart_q, POS_BITS'(1), E_NONE, sat_q);
				end
				default: ;
			endcase
		end
		if (restart && c_op) begin
			cv[1] = 1'b1;
			cr[1] = mk(op_code(c), pos_q, POS_BITS'(1), E_NONE, sat_q);
		end else if (restart && c_unknown) begin
			cv[1] = 1'b1;
			cr[1] = mk(T_IDENT, pos_q, POS_BITS'(1), E_UNKNOWN, sat_q);
		end
		if (end_take) begin
			unique case (mode_b)
				M_WORD: begin
					cv[2] = 1'b1;
					cr[2] = mk(kw_b, tstart_b, tlen_b, E_NONE, sat_b);
				end
				M_INT, M_FRAC: begin
					cv[2] = 1'b1;
					cr[2] = mk(T_NUMBER, tstart_b, tlen_b, E_NONE, sat_b);
				end
				M_LT: begin
					cv[2] = 1'b1;
					cr[2] = mk(T_LT, tstart_b, POS_BITS'(1), E_NONE, sat_b);
				end
				M_GT: begin
					cv[2] = 1'b1;
					cr[2] = mk(T_GT, tstart_b, POS_BITS'(1), E_NONE, sat_b);
				end
				M_STR, M_ESC: begin
					cv[2] = 1'b1;
					cr[2] = mk(T_STRING, tstart_b, tlen_b, E_UNTERM, sat_b);
				end
				default: ;
			endcase
			cv[3] = 1'b1;
			cr[3] = mk(T_END, pos_b, '0, E_NONE, sat_b);
		end
		// pack; at most three candidates are ever valid together
		push = '0;
		for (int j = 0; j < 4; j++) begin
			if (cv[j] && push.n != 2'd3) begin
				push.slot[push.n] = cr[j];
				push.n = push.n + 2'd1;
			end
		end
		if (push.n != 2'd0) push.slot[push.n - 2'd1].last_of_run = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			tstart_q <= '0;
			tlen_q   <= '0;
			pos_q    <= '0;
			sat_q    <= 1'b0;
		end else if (accept) begin
			mode_q   <= mode_n;
			tstart_q <= tstart_n;
			tlen_q   <= tlen_n;
			pos_q    <= pos_n;
			sat_q    <= sat_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) wbuf_q <= wbuf_b;
	end

`ifndef ASSERT_OFF
	a_idle_no_rec: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !text.has_char && !text.last) |-> (push.n == 2'd0))
		else $error("record from an empty item");
	a_err_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mode_q == M_ERR && !text.last) |-> (push.n == 2'd0))
		else $error("record after unknown character");
	a_end_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && text.last) |=> (mode_q == M_IDLE && pos_q == '0 && !sat_q))
		else $error("state not cleared after end");
`endif

endmodule

### hw/rtl/stt_queue.sv
// Token record queue and output register.
module stt_queue import stt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	output logic  full,
	output logic  token_valid,
	input  logic  token_stall,
	output out_t  token
);

	out_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic               valid_q;
	out_t               token_q;
	logic               pop;

	// room for a worst-case byte (three records) must exist
	assign full = (cnt_q > Q_CNT_W'(Q_DEPTH - 3));
	assign pop  = (cnt_q != '0) && (!valid_q || !token_stall);

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (2'(i) < push.n) mem_q[Q_PTR_W'(wr_ptr_q + Q_PTR_W'(i))] <= push.slot[i];
		end
		if (pop) token_q <= mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			valid_q  <= 1'b0;
		end else begin
			wr_ptr_q <= Q_PTR_W'(wr_ptr_q + Q_PTR_W'(push.n));
			rd_ptr_q <= Q_PTR_W'(rd_ptr_q + Q_PTR_W'(pop));
			cnt_q    <= Q_CNT_W'(cnt_q + Q_CNT_W'(push.n) - Q_CNT_W'(pop));
			if (pop) valid_q <= 1'b1;
			else if (!token_stall) valid_q <= 1'b0;
		end
	end

	assign token_valid = valid_q;
	assign token       = token_q;

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Q_CNT_W'(Q_DEPTH))
		else $error("queue count beyond depth");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> (push.n == 2'd0))
		else $error("push while full");
	a_fill_out: assert property (@(posedge clk) disable iff (!arst_n)
		(!valid_q && cnt_q != '0) |=> valid_q)
		else $error("output register not loaded");
`endif

endmodule

### dv/sql_text_tokenizer_checker.sv
// Token checker: watches both channels, predicts token records and compares them.
module sql_text_tokenizer_checker import stt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic text_valid,
	input  logic text_stall,
	input  in_t  text,
	input  logic token_valid,
	input  logic token_stall,
	input  out_t token,
	output int   fail_count,
	output int   pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PMAX = 65535;
	localparam int WMAX = 14;

	string kw_names [27] = '{"SELECT", "FROM", "WHERE", "AND", "OR", "ORDER", "GROUP", "BY",
		"CREATE", "DATABASE", "TABLE", "IN", "PRIMARY", "KEY", "UNIQUE", "NOT", "NULL",
		{"AUTO_", "INCREMENT"}, "INSERT", "INTO", "VALUES", "UPDATE", "SET", "DELETE", "USE",
		"DESCRIBE", "CATALOG"};

	lex_mode_t  mode;
	logic [7:0] word [WMAX];
	int         tok_start, tok_len, pos;
	logic       sat;
	out_t       expected_tokens [$];
	out_t       step_recs [$];

	assign pending_count = expected_tokens.size();

	function automatic int bump(int v);
		if (v >= PMAX) begin
			sat = 1'b1;
			return PMAX;
		end
		return v + 1;
	endfunction

	function automatic void push_rec(logic [5:0] t, int s, int l, logic [1:0] e);
		out_t r;
		r.token_type = t;
		r.start_pos = s[15:0];
		r.token_len = l[15:0];
		r.error_code = e;
		r.overflow = sat;
		r.last_of_run = 1'b0;
		if (step_recs.size() < 3) step_recs.push_back(r);
	endfunction

	function automatic bit is_letter(logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic bit is_num(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic void word_done();
		logic [5:0] t;
		bit hit;
		t = T_IDENT;
		if (tok_len <= WMAX)
			for (int k = 0; k < 27; k++) begin
				hit = kw_names[k].len() == tok_len;
				for (int i = 0; hit && i < tok_len; i++)
					hit = word[i] == kw_names[k][i];
				if (hit) begin
					t = T_KW_BASE + 6'(k);
					break;
				end
			end
		push_rec(t, tok_start, tok_len, E_NONE);
	endfunction

	function automatic void start_token(logic [7:0] c, int p);
		case (c)
			"+": begin push_rec(T_PLUS, p, 1, E_NONE); return; end
			"-": begin push_rec(T_MINUS, p, 1, E_NONE); return; end
			"*": begin push_rec(T_STAR, p, 1, E_NONE); return; end
			"/": begin push_rec(T_SLASH, p, 1, E_NONE); return; end
			"=": begin push_rec(T_EQ, p, 1, E_NONE); return; end
			",": begin push_rec(T_COMMA, p, 1, E_NONE); return; end
			";": begin push_rec(T_SEMI, p, 1, E_NONE); return; end
			"(": begin push_rec(T_LPAREN, p, 1, E_NONE); return; end
			")": begin push_rec(T_RPAREN, p, 1, E_NONE); return; end
			default: ;
		endcase
		if (c == " " || (c >= 9 && c <= 13)) return;
		tok_start = p;
		tok_len = 1;
		if (is_letter(c) || c == CH_US) begin
			word[0] = c;
			mode = M_WORD;
		end else if (is_num(c)) mode = M_INT;
		else if (c == CH_LT) mode = M_LT;
		else if (c == CH_GT) mode = M_GT;
		else if (c == CH_QUOTE) begin
			tok_start = bump(p);
			tok_len = 0;
			mode = M_STR;
		end else begin
			push_rec(T_IDENT, p, 1, E_UNKNOWN);
			mode = M_ERR;
		end
	endfunction

	function automatic void lex_byte(logic [7:0] c, int p);
		case (mode)
			M_IDLE: begin start_token(c, p); return; end
			M_WORD: begin
				if (is_letter(c) || is_num(c) || c == CH_US) begin
					if (tok_len < WMAX) word[tok_len] = c;
					tok_len = bump(tok_len);
					return;
				end
				word_done();
			end
			M_STR: begin
				if (c == CH_QUOTE) begin
					push_rec(T_STRING, tok_start, tok_len, E_NONE);
					mode = M_IDLE;
					return;
				end
				if (c == CH_BSLASH) mode = M_ESC;
				tok_len = bump(tok_len);
				return;
			end
			M_ESC: begin
				tok_len = bump(tok_len);
				mode = M_STR;
				return;
			end
			M_INT, M_FRAC: begin
				if (is_num(c)) begin
					tok_len = bump(tok_len);
					return;
				end
				if (c == CH_DOT && mode == M_INT) begin
					tok_len = bump(tok_len);
					mode = M_FRAC;
					return;
				end
				push_rec(T_NUMBER, tok_start, tok_len, E_NONE);
			end
			M_LT, M_GT: begin
				if (c == CH_EQ) begin
					push_rec(mode == M_LT ? T_LTEQ : T_GTEQ, tok_start, 2, E_NONE);
					mode = M_IDLE;
					return;
				end
				push_rec(mode == M_LT ? T_LT : T_GT, tok_start, 1, E_NONE);
			end
			default: return;
		endcase
		mode = M_IDLE;
		start_token(c, p);
	endfunction

	function automatic void clear_state();
		mode = M_IDLE;
		tok_start = 0;
		tok_len = 0;
		pos = 0;
		sat = 1'b0;
	endfunction

	function automatic void predict_tokens(in_t it);
		step_recs.delete();
		if (it.has_char) begin
			lex_byte(it.ch, pos);
			pos = bump(pos);
		end
		if (it.last) begin
			case (mode)
				M_WORD: word_done();
				M_INT, M_FRAC: push_rec(T_NUMBER, tok_start, tok_len, E_NONE);
				M_LT: push_rec(T_LT, tok_start, 1, E_NONE);
				M_GT: push_rec(T_GT, tok_start, 1, E_NONE);
				M_STR, M_ESC: push_rec(T_STRING, tok_start, tok_len, E_UNTERM);
				default: ;
			endcase
			push_rec(T_END, pos, 0, E_NONE);
			clear_state();
		end
		if (step_recs.size() > 0) step_recs[step_recs.size() - 1].last_of_run = 1'b1;
		foreach (step_recs[i]) expected_tokens.push_back(step_recs[i]);
	endfunction

	initial begin
		clear_state();
		fail_count = 0;
	end

	always @(posedge clk) begin
		out_t want;
		if (arst_n && token_valid && !token_stall) begin
			if (expected_tokens.size() == 0) begin
				fail_count++;
				if (fail_count <= 10) $display("unexpected token %p", token);
			end else begin
				want = expected_tokens.pop_front();
				if (want !== token) begin
					fail_count++;
					if (fail_count <= 10)
						$display("token mismatch: exp %p got %p", want, token);
				end
			end
		end
		if (arst_n && text_valid && !text_stall) predict_tokens(text);
	end
endmodule

### dv/sql_text_tokenizer_tb.sv
// Testbench top: clock, reset, text stimulus, token stall control and verdict.
module sql_text_tokenizer_tb import stt_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic text_valid = 1'b0;
	logic text_stall;
	in_t  text = '0;
	logic token_valid;
	logic token_stall = 1'b0;
	out_t token;
	int   fail_count, pending_count;
	int   idle_cycles = 0;
	bit   hold_sink = 1'b0;
	bit   drain_wait = 1'b0;

	string sample_words [12] = '{"SELECT", "from", {"AUTO_", "INCREMENT"}, "WHERE", "x_1",
		"_tmp", "CATALOG", {"AUTO_", "INCREMENTS"}, "DESCRIBE", "In", "abcdefghijklmnopq",
		"NULL"};
	string sample_ops [14] = '{"+", "-", "*", "/", "=", "<", ">", "<=", ">=", ",", ";",
		"(", ")", " "};

	sql_text_tokenizer i_dut (
		.clk(clk), .arst_n(arst_n), .text_valid(text_valid), .text_stall(text_stall),
		.text(text), .token_valid(token_valid), .token_stall(token_stall), .token(token)
	);

	sql_text_tokenizer_checker i_checker (
		.clk(clk), .arst_n(arst_n), .text_valid(text_valid), .text_stall(text_stall),
		.text(text), .token_valid(token_valid), .token_stall(token_stall), .token(token),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// one transfer on the text channel, with a random gap first
	task automatic send_byte(logic [7:0] c, logic hc, logic lst);
		int gap;
		gap = drain_wait ? 0 : $urandom_range(0, 14);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			text_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		text_valid <= 1'b1;
		text <= '{ch: c, has_char: hc, last: lst};
		do @(posedge clk); while (text_stall);
		@(negedge clk);
	endtask

	task automatic send_str(string s, bit lst);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b1, lst && i == s.len() - 1);
	endtask

	task automatic send_random_stmt();
		int n;
		n = $urandom_range(2, 10);
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(0, 6))
				0, 1: send_str(sample_words[$urandom_range(0, 11)], 1'b0);
				2: send_str(sample_ops[$urandom_range(0, 13)], 1'b0);
				3: begin
					send_byte(8'("0" + $urandom_range(0, 9)), 1'b1, 1'b0);
					if ($urandom_range(0, 1) != 0) send_str("7.25", 1'b0);
				end
				4: begin
					if ($urandom_range(0, 1) != 0) send_str("'a\\'b c'", 1'b0);
					else send_str("'it''s'", 1'b0);
				end
				5: send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);
				default: send_byte(" ", 1'b1, 1'b0);
			endcase
		end
		case ($urandom_range(0, 3))
			0: send_byte(";", 1'b1, 1'b1);
			1: send_byte(8'h00, 1'b0, 1'b1);
			2: send_byte(8'("a" + $urandom_range(0, 25)), 1'b1, 1'b1);
			default: send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b1);
		endcase
	endtask

	always @(negedge clk) begin
		if (hold_sink) token_stall <= 1'b1;
		else if (idle_cycles > 0) begin
			idle_cycles <= idle_cycles - 1;
			token_stall <= 1'b1;
		end else if (token_valid && !token_stall) begin
			idle_cycles <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
			token_stall <= 1'b0;
		end else token_stall <= 1'b0;
	end

	// watchdog on cycles with no transfer
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((text_valid && !text_stall) || (token_valid && !token_stall)) quiet = 0;
			else quiet++;
			if (quiet >= 2000) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// directed
		send_str("SELECT a_1,b FROM t WHERE x<=10.5;", 1'b1);
		send_str({">=<>AUTO_", "INCREMENT 'q\\'"}, 1'b1);
		send_byte(8'hFF, 1'b1, 1'b0);
		send_byte("x", 1'b1, 1'b1);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b1);
		send_str("'ab'(7)", 1'b1);
		// long receiver hold while text keeps coming
		fork
			begin
				hold_sink = 1'b1;
				repeat (60) @(negedge clk);
				hold_sink = 1'b0;
			end
			repeat (3) send_random_stmt();
		join
		// drain before the next text
		text_valid <= 1'b0;
		drain_wait = 1'b1;
		wait (pending_count == 0);
		repeat (10) @(negedge clk);
		send_random_stmt();
		drain_wait = 1'b0;
		repeat (7) send_random_stmt();
		text_valid <= 1'b0;
		fork
			wait (pending_count == 0);
			begin
				repeat (200000) @(posedge clk);
				$display("FAILED: results differ");
				$finish;
			end
		join_any
		disable fork;
		repeat (20) @(negedge clk);
		if (fail_count == 0) $display("PASSED: all results match");
		else $display("FAILED: results differ");
		$finish;
	end
endmodule
